@@ rtl/qmnf_pkg.sv @@
// ----------------------------------------------------------------------------
// qmnf_pkg
// Shared types and constants of the quad mesh neighbor finder.
// ----------------------------------------------------------------------------
package qmnf_pkg;

  localparam int LANES    = 4;
  localparam int LANE_W   = 2;
  localparam int SLOTS    = 4;
  localparam int SLOT_W   = 2;
  localparam int IDX_W    = 6;
  localparam int NBR_W    = 7;
  localparam int CNT_BITS = 3;

  localparam logic [NBR_W-1:0] NO_NBR = '1;

  typedef struct packed {
    logic [SLOTS-1:0][IDX_W-1:0] slot;
    logic [CNT_BITS-1:0]         count;
  } nbr_rec_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] cell_id;
    nbr_rec_t         rec;
  } lane_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW_RD,
    S_ROW_LD,
    S_SCAN,
    S_DRAIN,
    S_WB,
    S_OUT
  } state_t;

endpackage

@@ rtl/qmnf_bank.sv @@
// ----------------------------------------------------------------------------
// qmnf_bank
// One bank of cell storage: edge identifiers and neighbor record per row,
// registered read.
// ----------------------------------------------------------------------------
module qmnf_bank import qmnf_pkg::*; #(
  parameter int EDGE_W = 16,
  parameter int ROW_W  = 4
) (
  input  logic                             clk,
  input  logic [ROW_W-1:0]                 rd_row,
  input  logic [ROW_W-1:0]                 wr_row,
  input  logic                             edge_we,
  input  logic [SLOTS-1:0][EDGE_W-1:0]     edge_wdata,
  input  logic                             rec_we,
  input  nbr_rec_t                         rec_wdata,
  output logic [SLOTS-1:0][EDGE_W-1:0]     edge_rdata,
  output nbr_rec_t                         rec_rdata
);

  localparam int DEPTH = 1 << ROW_W;

  logic [SLOTS-1:0][EDGE_W-1:0] edge_mem [DEPTH];
  nbr_rec_t                     rec_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[wr_row] <= edge_wdata;
    end
    if (rec_we) begin
      rec_mem[wr_row] <= rec_wdata;
    end
    edge_rdata <= edge_mem[rd_row];
    rec_rdata  <= rec_mem[rd_row];
  end

endmodule

@@ rtl/qmnf_lane.sv @@
// ----------------------------------------------------------------------------
// qmnf_lane
// Shared-edge test of the current cell against one candidate cell.
// ----------------------------------------------------------------------------
module qmnf_lane import qmnf_pkg::*; #(
  parameter int EDGE_W = 16
) (
  input  logic                         valid,
  input  logic                         first_row,
  input  logic [IDX_W-1:0]             cell_id,
  input  logic [SLOTS-1:0][EDGE_W-1:0] edge_i,
  input  logic [SLOTS-1:0][EDGE_W-1:0] edge_j,
  input  nbr_rec_t                     rec_j,
  output lane_res_t                    res
);

  logic match;

  always_comb begin
    match = 1'b0;
    for (int p = 0; p < SLOTS; p++) begin
      for (int q = 0; q < SLOTS; q++) begin
        if (edge_i[p] == edge_j[q]) begin
          match = 1'b1;
        end
      end
    end
    res         = '0;
    res.valid   = valid;
    res.hit     = valid && match;
    res.cell_id = cell_id;
    res.rec     = rec_j;
    if (first_row) begin
      res.rec.count = '0;
    end
  end

endmodule

@@ rtl/qmnf_merge.sv @@
// ----------------------------------------------------------------------------
// qmnf_merge
// Combine lane hits in ascending cell order into the current cell's record
// and the candidate records.
// ----------------------------------------------------------------------------
module qmnf_merge import qmnf_pkg::*; (
  input  lane_res_t [LANES-1:0] lanes,
  input  nbr_rec_t              rec_i,
  input  logic [IDX_W-1:0]      cell_i,
  output nbr_rec_t [LANES-1:0]  rec_j_next,
  output nbr_rec_t              rec_i_next
);

  localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(SLOTS);
  localparam logic [CNT_BITS-1:0] ONE  = CNT_BITS'(1);

  nbr_rec_t acc;

  always_comb begin
    acc = rec_i;
    for (int l = 0; l < LANES; l++) begin
      rec_j_next[l] = lanes[l].rec;
      if (lanes[l].hit && (lanes[l].rec.count < FULL) && (acc.count < FULL)) begin
        rec_j_next[l].slot[lanes[l].rec.count[SLOT_W-1:0]] = cell_i;
        rec_j_next[l].count = lanes[l].rec.count + ONE;
        acc.slot[acc.count[SLOT_W-1:0]] = lanes[l].cell_id;
        acc.count = acc.count + ONE;
      end
    end
    rec_i_next = acc;
  end

endmodule

@@ rtl/quad_mesh_neighbor_finder_top.sv @@
// ----------------------------------------------------------------------------
// quad_mesh_neighbor_finder_top
// Load quad cells, find neighbors sharing an edge, report four slots per cell.
//
//   channel   direction  handshake                 payload
//   cells     in         start & !busy             edge_a..edge_d, final_cell
//   results   out        result_strobe (no stall)  cell_index, neighbor_*,
//                                                  last_result
//
// After the final cell, each cell i passes through row read, row load, a scan
// of each four-cell group from the group holding cell i+1 through the last
// group, drain and write-back; the last cell skips scan and drain. Then one
// result per cycle for the n cells. busy is high from the final cell until
// the last result read is issued. Reset is synchronous; results cannot be
// held off.
// ----------------------------------------------------------------------------
module quad_mesh_neighbor_finder_top import qmnf_pkg::*; #(
  parameter int MAX_CELLS    = 64,
  parameter int EDGE_ID_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [15:0]             edge_a,
  input  logic [15:0]             edge_b,
  input  logic [15:0]             edge_c,
  input  logic [15:0]             edge_d,
  input  logic                    final_cell,
  output logic                    result_strobe,
  output logic [IDX_W-1:0]        cell_index,
  output logic signed [NBR_W-1:0] neighbor_first,
  output logic signed [NBR_W-1:0] neighbor_second,
  output logic signed [NBR_W-1:0] neighbor_third,
  output logic signed [NBR_W-1:0] neighbor_fourth,
  output logic                    last_result
);

  localparam int EDGE_W = (EDGE_ID_BITS < 16) ? EDGE_ID_BITS : 16;
  localparam int DEPTH  = (MAX_CELLS + LANES - 1) / LANES;
  localparam int ROW_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_CELLS + 1);
  localparam int CW     = (CNT_W > ROW_W + LANE_W) ? CNT_W : ROW_W + LANE_W;
  localparam int JW     = CW + 1;

  state_t state, state_next;

  logic [CW-1:0]                cells_loaded;
  logic [CW-1:0]                i_cnt;
  logic [JW-1:0]                jb;
  logic [CW-1:0]                k_cnt;
  logic [SLOTS-1:0][EDGE_W-1:0] edge_i;
  nbr_rec_t                     rec_i;
  logic                         p_active;
  logic [LANES-1:0]             p_valid;
  logic [LANES-1:0][IDX_W-1:0]  p_cell;
  logic [ROW_W-1:0]             p_row;
  logic [LANE_W-1:0]            o_lane;
  logic [IDX_W-1:0]             o_cell;
  logic                         o_last;

  logic                                     accept;
  logic                                     store_ok;
  logic [JW-1:0]                            n_ext;
  logic [JW-1:0]                            i_plus;
  logic [JW-1:0]                            k_plus;
  logic                                     last_group;
  logic [LANES-1:0][JW-1:0]                 issue_cell;
  logic [LANES-1:0]                         issue_valid;
  logic [ROW_W-1:0]                         rd_row;
  logic [ROW_W-1:0]                         wr_row;
  logic [SLOTS-1:0][EDGE_W-1:0]             edge_in;
  logic [LANES-1:0]                         edge_we;
  logic [LANES-1:0]                         rec_we;
  nbr_rec_t [LANES-1:0]                     rec_wdata;
  logic [LANES-1:0][SLOTS-1:0][EDGE_W-1:0]  edge_rd;
  nbr_rec_t [LANES-1:0]                     rec_rd;
  lane_res_t [LANES-1:0]                    lane_res;
  nbr_rec_t [LANES-1:0]                     rec_j_next;
  nbr_rec_t                                 rec_i_next;
  nbr_rec_t                                 rec_o;
  logic [SLOTS-1:0][NBR_W-1:0]              nbr_out;

  assign accept     = start && !busy;
  assign store_ok   = cells_loaded < CW'(MAX_CELLS);
  assign n_ext      = JW'(cells_loaded);
  assign i_plus     = JW'(i_cnt) + JW'(1);
  assign k_plus     = JW'(k_cnt) + JW'(1);
  assign last_group = (jb + JW'(LANES)) >= n_ext;

  assign edge_in[0] = edge_a[EDGE_W-1:0];
  assign edge_in[1] = edge_b[EDGE_W-1:0];
  assign edge_in[2] = edge_c[EDGE_W-1:0];
  assign edge_in[3] = edge_d[EDGE_W-1:0];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      issue_cell[l]  = jb + JW'(l);
      issue_valid[l] = (issue_cell[l] > JW'(i_cnt)) && (issue_cell[l] < n_ext);
    end
  end

  always_comb begin
    case (state)
      S_ROW_RD: rd_row = i_cnt[LANE_W +: ROW_W];
      S_SCAN:   rd_row = jb[LANE_W +: ROW_W];
      S_OUT:    rd_row = k_cnt[LANE_W +: ROW_W];
      default:  rd_row = '0;
    endcase
  end

  always_comb begin
    if (state == S_WB) begin
      wr_row = i_cnt[LANE_W +: ROW_W];
    end else if (p_active) begin
      wr_row = p_row;
    end else begin
      wr_row = cells_loaded[LANE_W +: ROW_W];
    end
    for (int b = 0; b < LANES; b++) begin
      edge_we[b]   = accept && store_ok && (cells_loaded[LANE_W-1:0] == LANE_W'(b));
      rec_we[b]    = (p_active && p_valid[b]) ||
                     ((state == S_WB) && (i_cnt[LANE_W-1:0] == LANE_W'(b)));
      rec_wdata[b] = (state == S_WB) ? rec_i : rec_j_next[b];
    end
  end

  for (genvar b = 0; b < LANES; b++) begin : g_lane
    qmnf_bank #(
      .EDGE_W (EDGE_W),
      .ROW_W  (ROW_W)
    ) u_bank (
      .clk        (clk),
      .rd_row     (rd_row),
      .wr_row     (wr_row),
      .edge_we    (edge_we[b]),
      .edge_wdata (edge_in),
      .rec_we     (rec_we[b]),
      .rec_wdata  (rec_wdata[b]),
      .edge_rdata (edge_rd[b]),
      .rec_rdata  (rec_rd[b])
    );

    qmnf_lane #(
      .EDGE_W (EDGE_W)
    ) u_lane (
      .valid     (p_active && p_valid[b]),
      .first_row (i_cnt == '0),
      .cell_id   (p_cell[b]),
      .edge_i    (edge_i),
      .edge_j    (edge_rd[b]),
      .rec_j     (rec_rd[b]),
      .res       (lane_res[b])
    );
  end

  qmnf_merge u_merge (
    .lanes      (lane_res),
    .rec_i      (rec_i),
    .cell_i     (IDX_W'(i_cnt)),
    .rec_j_next (rec_j_next),
    .rec_i_next (rec_i_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (accept && final_cell) begin
          state_next = S_ROW_RD;
        end
      end
      S_ROW_RD: state_next = S_ROW_LD;
      S_ROW_LD: begin
        if (i_plus >= n_ext) begin
          state_next = S_WB;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_group) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_WB;
      S_WB: begin
        if (i_plus == n_ext) begin
          state_next = S_OUT;
        end else begin
          state_next = S_ROW_RD;
        end
      end
      S_OUT: begin
        if (k_plus == n_ext) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_loaded  <= '0;
      i_cnt         <= '0;
      k_cnt         <= '0;
      p_active      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      p_active      <= (state == S_SCAN);
      result_strobe <= (state == S_OUT);
      case (state)
        S_IDLE: begin
          i_cnt <= '0;
          if (accept && store_ok) begin
            cells_loaded <= cells_loaded + CW'(1);
          end
        end
        S_WB: begin
          i_cnt <= CW'(i_plus);
          k_cnt <= '0;
        end
        S_OUT: begin
          k_cnt <= CW'(k_plus);
          if (k_plus == n_ext) begin
            cells_loaded <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ROW_LD) begin
      edge_i <= edge_rd[i_cnt[LANE_W-1:0]];
      rec_i  <= (i_cnt == '0) ? nbr_rec_t'('0) : rec_rd[i_cnt[LANE_W-1:0]];
      jb     <= i_plus & ~JW'(LANES - 1);
    end else begin
      if (p_active) begin
        rec_i <= rec_i_next;
      end
      if (state == S_SCAN) begin
        jb <= jb + JW'(LANES);
      end
    end
    p_row <= jb[LANE_W +: ROW_W];
    for (int l = 0; l < LANES; l++) begin
      p_valid[l] <= issue_valid[l];
      p_cell[l]  <= IDX_W'(issue_cell[l]);
    end
    o_lane <= k_cnt[LANE_W-1:0];
    o_cell <= IDX_W'(k_cnt);
    o_last <= (k_plus == n_ext);
  end

  assign rec_o = rec_rd[o_lane];

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      if (rec_o.count > CNT_BITS'(s)) begin
        nbr_out[s] = {1'b0, rec_o.slot[s]};
      end else begin
        nbr_out[s] = NO_NBR;
      end
    end
  end

  assign cell_index      = o_cell;
  assign last_result     = o_last;
  assign neighbor_first  = nbr_out[0];
  assign neighbor_second = nbr_out[1];
  assign neighbor_third  = nbr_out[2];
  assign neighbor_fourth = nbr_out[3];

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DRAIN || state == S_WB) |->
      rec_i.count <= CNT_BITS'(SLOTS))
    else $error("current cell holds more than four neighbors");

  a_store_cap: assert property (@(posedge clk) disable iff (rst)
    cells_loaded <= CW'(MAX_CELLS))
    else $error("cell store overfilled");

  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && final_cell) |=> busy)
    else $error("final cell did not start the search");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_result) |=> !result_strobe)
    else $error("result after the last result");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_result) |=>
      (result_strobe && cell_index == IDX_W'($past(cell_index) + 1'b1)))
    else $error("results not in consecutive cell order");

endmodule

@@ verif/tb_quad_mesh_neighbor_finder_top.sv @@
// ----------------------------------------------------------------------------
// tb_quad_mesh_neighbor_finder_top
// Self-checking bench for the quad mesh neighbor finder.
//
// Loads meshes of quad cells, one cell per transaction with bursty start
// traffic, and predicts the neighbor slots of every cell. Each reported cell
// is compared in every field against the oldest predicted report. Covers
// single cells, cells with no shared edge, fully shared edges that saturate
// the four slots, store overflow past 64 cells and random meshes of varied
// edge density.
// ----------------------------------------------------------------------------
module tb_quad_mesh_neighbor_finder_top;
  import qmnf_pkg::*;

  localparam int CELLS = 64;
  localparam int ITEMS = 400;

  typedef struct packed {
    logic [IDX_W-1:0]            cell_id;
    logic [SLOTS-1:0][NBR_W-1:0] nbr;
    logic                        last;
  } cell_report_t;

  class adjacency_scoreboard;
    logic [15:0]  edge_id [CELLS][SLOTS];
    int           loaded;
    int           mismatches;
    cell_report_t reports [$];

    function void find_neighbors();
      int           slot [CELLS][SLOTS];
      int           cnt [CELLS];
      bit           shared;
      cell_report_t r;
      for (int i = 0; i < CELLS; i++) begin
        cnt[i] = 0;
        for (int s = 0; s < SLOTS; s++) slot[i][s] = -1;
      end
      for (int i = 0; i < loaded; i++) begin
        for (int j = i + 1; j < loaded; j++) begin
          if (cnt[i] < SLOTS && cnt[j] < SLOTS) begin
            shared = 1'b0;
            for (int p = 0; p < SLOTS; p++)
              for (int q = 0; q < SLOTS; q++)
                if (edge_id[i][p] == edge_id[j][q]) shared = 1'b1;
            if (shared) begin
              slot[i][cnt[i]] = j;
              slot[j][cnt[j]] = i;
              cnt[i]++;
              cnt[j]++;
            end
          end
        end
      end
      for (int k = 0; k < loaded; k++) begin
        r.cell_id = IDX_W'(k);
        for (int s = 0; s < SLOTS; s++) r.nbr[s] = NBR_W'(slot[k][s]);
        r.last = (k == loaded - 1);
        reports.push_back(r);
      end
    endfunction

    function void load_cell(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                            logic [15:0] d, logic fin);
      if (loaded < CELLS) begin
        edge_id[loaded][0] = a;
        edge_id[loaded][1] = b;
        edge_id[loaded][2] = c;
        edge_id[loaded][3] = d;
        loaded++;
      end
      if (fin) begin
        find_neighbors();
        loaded = 0;
      end
    endfunction

    function void check_report(cell_report_t got);
      cell_report_t want;
      if (reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: cell %0d nbr %0d %0d %0d %0d last %b",
                   got.cell_id, $signed(got.nbr[0]), $signed(got.nbr[1]),
                   $signed(got.nbr[2]), $signed(got.nbr[3]), got.last);
        return;
      end
      want = reports.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected cell %0d nbr %0d %0d %0d %0d last %b,",
                   want.cell_id, $signed(want.nbr[0]), $signed(want.nbr[1]),
                   $signed(want.nbr[2]), $signed(want.nbr[3]), want.last,
                   " got cell %0d nbr %0d %0d %0d %0d last %b",
                   got.cell_id, $signed(got.nbr[0]), $signed(got.nbr[1]),
                   $signed(got.nbr[2]), $signed(got.nbr[3]), got.last);
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [15:0]             edge_a = '0;
  logic [15:0]             edge_b = '0;
  logic [15:0]             edge_c = '0;
  logic [15:0]             edge_d = '0;
  logic                    final_cell = 1'b0;
  logic                    result_strobe;
  logic [IDX_W-1:0]        cell_index;
  logic signed [NBR_W-1:0] neighbor_first;
  logic signed [NBR_W-1:0] neighbor_second;
  logic signed [NBR_W-1:0] neighbor_third;
  logic signed [NBR_W-1:0] neighbor_fourth;
  logic                    last_result;

  adjacency_scoreboard board = new();
  int                  burst_left = 1;
  int                  sent = 0;

  quad_mesh_neighbor_finder_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .edge_a          (edge_a),
    .edge_b          (edge_b),
    .edge_c          (edge_c),
    .edge_d          (edge_d),
    .final_cell      (final_cell),
    .result_strobe   (result_strobe),
    .cell_index      (cell_index),
    .neighbor_first  (neighbor_first),
    .neighbor_second (neighbor_second),
    .neighbor_third  (neighbor_third),
    .neighbor_fourth (neighbor_fourth),
    .last_result     (last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cell_report_t got;
    if (!rst && result_strobe) begin
      got.cell_id = cell_index;
      got.nbr[0]  = neighbor_first;
      got.nbr[1]  = neighbor_second;
      got.nbr[2]  = neighbor_third;
      got.nbr[3]  = neighbor_fourth;
      got.last    = last_result;
      board.check_report(got);
    end
  end

  task automatic send_cell(input logic [15:0] a, input logic [15:0] b,
                           input logic [15:0] c, input logic [15:0] d,
                           input logic fin);
    start      <= 1'b1;
    edge_a     <= a;
    edge_b     <= b;
    edge_c     <= c;
    edge_d     <= d;
    final_cell <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.load_cell(a, b, c, d, fin);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  endtask

  task automatic send_mesh(input int n);
    logic [15:0] base;
    logic [15:0] e [SLOTS];
    int          span;
    base = 16'($urandom);
    span = ($urandom_range(0, 4) == 0) ? 65536 : $urandom_range(1, 4 * n + 4);
    for (int k = 0; k < n; k++) begin
      for (int s = 0; s < SLOTS; s++)
        e[s] = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                            : base + 16'($urandom_range(0, span - 1));
      send_cell(e[0], e[1], e[2], e[3], k == n - 1);
    end
  endtask

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cell(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_cell(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_cell(16'h0001, 16'h0002, 16'h0003, 16'hFFFF, 1'b1);
    send_cell(16'hA5A5, 16'h0001, 16'h0002, 16'h0003, 1'b0);
    send_cell(16'h5A5A, 16'h0005, 16'h0006, 16'h0007, 1'b1);
    for (int k = 0; k < 7; k++)
      send_cell(16'h0064, 16'h1000 + 16'(k), 16'h2000 + 16'(k), 16'h8000 + 16'(k),
                k == 6);
    for (int k = 0; k < 5; k++)
      send_cell(16'(k), 16'(k + 1), 16'h7FFF, 16'h7FFF, k == 4);

    send_mesh(66);
    send_mesh(CELLS);
    while (sent < ITEMS) begin
      case ($urandom_range(0, 11))
        0:       n = $urandom_range(30, CELLS);
        1:       n = 1;
        default: n = $urandom_range(2, 16);
      endcase
      send_mesh(n);
    end
    start <= 1'b0;

    while (board.reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
